// ===== design/efcd_pkg.sv =====
`default_nettype none

package efcd_pkg;

    // framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'hFF;
    localparam logic [7:0] ESC_BYTE  = 8'hFE;

    // reset value of the color command register, ascii 'c'
    localparam logic [7:0] COLOR_CODE_RESET = 8'd99;

    // default store depth in bytes, one slot kept free
    localparam int BUFFER_BYTES_DEFAULT = 32;

    // width of the reported payload length
    localparam int LEN_W = 5;

    // number of store positions that are ever reported
    localparam int FRONT_DEPTH = 4;

    // one frame report
    typedef struct packed {
        logic             valid;
        logic             checksum_ok;
        logic [LEN_W-1:0] payload_length;
        logic             is_color;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } t_result;

endpackage

`default_nettype wire

// ===== design/efcd_frame.sv =====
`default_nettype none

module efcd_frame
    import efcd_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_color_code,
    output t_result         o_result
);

    localparam int FILL_W = $clog2(BUFFER_BYTES);
    localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(BUFFER_BYTES - 1);
    localparam logic [FILL_W-1:0] FRONT_LIM  = FILL_W'(FRONT_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE   = FILL_W'(1);

    logic              r_escape;
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_sum;
    logic [7:0]        r_last;
    logic [7:0]        r_front [FRONT_DEPTH];

    logic              n_escape;
    logic [FILL_W-1:0] n_fill;
    logic [7:0]        n_sum;
    logic [7:0]        n_last;

    logic              is_flag;
    logic              is_esc;
    logic              do_store;
    logic              do_end;
    logic              can_store;
    logic [7:0]        payload_sum;
    logic              sum_ok;
    logic              col_hit;
    logic [FILL_W-1:0] len_full;
    logic [FILL_W+LEN_W-1:0] len_ext;

    // byte classification
    always_comb begin
        is_flag   = (i_byte == FLAG_BYTE);
        is_esc    = (i_byte == ESC_BYTE);
        can_store = (r_fill < FILL_MAX);
        do_store  = i_step && (r_escape || (!is_flag && !is_esc));
        do_end    = i_step && !r_escape && is_flag;
    end

    // checksum and report fields from the state before this byte
    always_comb begin
        payload_sum = r_sum - r_last;
        sum_ok      = ((payload_sum ^ 8'hFF) == r_last);
        col_hit     = sum_ok && (r_front[0] == i_color_code);
        len_full    = r_fill - FILL_ONE;
        len_ext     = {{LEN_W{1'b0}}, len_full};

        o_result.valid          = do_end && (r_fill > FILL_ONE);
        o_result.checksum_ok    = sum_ok;
        o_result.payload_length = len_ext[LEN_W-1:0];
        o_result.is_color       = col_hit;
        o_result.red            = col_hit ? r_front[1] : 8'd0;
        o_result.green          = col_hit ? r_front[2] : 8'd0;
        o_result.blue           = col_hit ? r_front[3] : 8'd0;
    end

    // next frame state
    always_comb begin
        n_escape = r_escape;
        n_fill   = r_fill;
        n_sum    = r_sum;
        n_last   = r_last;
        if (i_step) begin
            if (r_escape) begin
                n_escape = 1'b0;
            end else if (is_esc) begin
                n_escape = 1'b1;
            end
        end
        if (do_store && can_store) begin
            n_fill = r_fill + FILL_ONE;
            n_sum  = r_sum + i_byte;
            n_last = i_byte;
        end
        if (do_end) begin
            n_fill = '0;
            n_sum  = '0;
            n_last = '0;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= 1'b0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_last   <= '0;
        end else begin
            r_escape <= n_escape;
            r_fill   <= n_fill;
            r_sum    <= n_sum;
            r_last   <= n_last;
        end
    end

    // first store positions, kept across frames
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRONT_DEPTH; k++) begin
                r_front[k] <= '0;
            end
        end else if (do_store && can_store && (r_fill < FRONT_LIM)) begin
            r_front[r_fill[1:0]] <= i_byte;
        end
    end

endmodule

`default_nettype wire

// ===== design/escaped_frame_checksum_deframer.sv =====
`default_nettype none

// Byte-stuffed frame receiver with an inverted-sum checksum. One received byte
// is taken per transfer on the input channel; 0xFF ends a frame and 0xFE makes
// the next byte literal data. At a frame end with two or more stored bytes one
// report comes out: whether the last byte equals the inverted 8-bit sum of the
// bytes before it, the payload length, and for a color command with a good
// checksum (first byte equal to the color code register) the three bytes
// after it; otherwise the color fields read zero. Shorter frames give no
// report. Bytes beyond BUFFER_BYTES-1 in one frame are dropped. A byte is
// accepted every cycle while the output is not stalled; the report passes
// through the input register, then the result register, and a filled stage
// holds while the output is stalled. Write the color code register only
// while the block is idle.
module escaped_frame_checksum_deframer
    import efcd_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [7:0]       i_cfg_wr_data,
    input  wire logic             i_rx_valid,
    output logic                  o_rx_stall,
    input  wire logic [7:0]       i_rx_byte,
    output logic                  o_res_valid,
    input  wire logic             i_res_stall,
    output logic                  o_checksum_ok,
    output logic [LEN_W-1:0]      o_payload_length,
    output logic                  o_is_color,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue
);

    logic [7:0] r_color;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_result    r_out;

    logic       out_free;
    logic       in_free;
    logic       step;
    t_result    frame_res;

    // color command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_CODE_RESET;
        end else if (i_cfg_wr_en) begin
            r_color <= i_cfg_wr_data;
        end
    end

    // handshake between the two stages
    always_comb begin
        out_free     = !r_out.valid || !i_res_stall;
        step         = r_in_valid && out_free;
        in_free      = !r_in_valid || out_free;
        o_rx_stall   = !in_free;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // frame state and checksum
    efcd_frame #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_color_code (r_color),
        .o_result     (frame_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (out_free) begin
            r_out.valid <= step && frame_res.valid;
        end
        if (out_free && step && frame_res.valid) begin
            r_out.checksum_ok    <= frame_res.checksum_ok;
            r_out.payload_length <= frame_res.payload_length;
            r_out.is_color       <= frame_res.is_color;
            r_out.red            <= frame_res.red;
            r_out.green          <= frame_res.green;
            r_out.blue           <= frame_res.blue;
        end
    end

    // output ports
    assign o_res_valid      = r_out.valid;
    assign o_checksum_ok    = r_out.checksum_ok;
    assign o_payload_length = r_out.payload_length;
    assign o_is_color       = r_out.is_color;
    assign o_red            = r_out.red;
    assign o_green          = r_out.green;
    assign o_blue           = r_out.blue;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import efcd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int STORE_BYTES  = BUFFER_BYTES_DEFAULT;
    localparam int BLOCK_BYTES  = 110;
    localparam int BLOCK_COUNT  = 8;

    // one row of the directed stimulus table
    typedef struct packed {
        logic [7:0] rx;
        t_result    typed;
    } t_stim_row;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [7:0]       cfg_wr_data;
    logic             rx_valid;
    logic             rx_stall;
    logic [7:0]       rx_byte;
    logic             res_valid;
    logic             res_stall;
    logic             checksum_ok;
    logic [LEN_W-1:0] payload_length;
    logic             is_color;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;

    // shadow copy of the deframer state
    logic        esc_seen;
    int unsigned held_count;
    logic [7:0]  byte_sum;
    logic [7:0]  tail_byte;
    logic [7:0]  head_bytes [FRONT_DEPTH];
    logic [7:0]  color_code;

    t_result   expected_reports [$];
    t_result   want_report;
    t_stim_row dir_rows [$];

    int send_idle_pct;
    int res_stall_pct;
    int cycles;
    int errors;
    int rx_count;
    int report_count;
    int settings_count;
    int pause_count;

    escaped_frame_checksum_deframer dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_rx_valid       (rx_valid),
        .o_rx_stall       (rx_stall),
        .i_rx_byte        (rx_byte),
        .o_res_valid      (res_valid),
        .i_res_stall      (res_stall),
        .o_checksum_ok    (checksum_ok),
        .o_payload_length (payload_length),
        .o_is_color       (is_color),
        .o_red            (red),
        .o_green          (green),
        .o_blue           (blue)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // store one data byte, dropped once the store is full
    task automatic hold_byte(input logic [7:0] b);
        if (held_count < STORE_BYTES - 1) begin
            if (held_count < FRONT_DEPTH) head_bytes[held_count] = b;
            byte_sum   = byte_sum + b;
            tail_byte  = b;
            held_count = held_count + 1;
        end
    endtask

    // advance the shadow state by one byte, queue the frame report if any
    task automatic deframe_byte(input logic [7:0] b, input t_result typed);
        t_result    rep;
        logic [7:0] body_sum;
        logic       good;
        logic       col;
        if (esc_seen) begin
            hold_byte(b);
            esc_seen = 1'b0;
        end else if (b == FLAG_BYTE) begin
            if (held_count > 1) begin
                body_sum           = byte_sum - tail_byte;
                good               = (~body_sum) == tail_byte;
                col                = good && (head_bytes[0] == color_code);
                rep.valid          = 1'b1;
                rep.checksum_ok    = good;
                rep.payload_length = LEN_W'(held_count - 1);
                rep.is_color       = col;
                rep.red            = col ? head_bytes[1] : 8'h00;
                rep.green          = col ? head_bytes[2] : 8'h00;
                rep.blue           = col ? head_bytes[3] : 8'h00;
                expected_reports.push_back(typed.valid ? typed : rep);
            end
            held_count = 0;
            byte_sum   = 8'h00;
            tail_byte  = 8'h00;
        end else if (b == ESC_BYTE) begin
            esc_seen = 1'b1;
        end else begin
            hold_byte(b);
        end
    endtask

    function automatic t_result typed_report(input logic ok, input int len, input logic col,
                                             input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] bl);
        t_result rep;
        rep.valid          = 1'b1;
        rep.checksum_ok    = ok;
        rep.payload_length = LEN_W'(len);
        rep.is_color       = col;
        rep.red            = r;
        rep.green          = g;
        rep.blue           = bl;
        return rep;
    endfunction

    task automatic add_row(input logic [7:0] b, input t_result typed);
        t_stim_row row;
        row.rx    = b;
        row.typed = typed;
        dir_rows.push_back(row);
    endtask

    // one byte transfer on the input channel, with random gaps
    task automatic send_byte(input logic [7:0] b, input t_result typed);
        if ($urandom_range(0, 299) == 0) begin
            rx_valid <= 1'b0;
            @(posedge clk);
            while (expected_reports.size() != 0) @(posedge clk);
            pause_count++;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        rx_count++;
        deframe_byte(b, typed);
    endtask

    // data byte, escaped when it looks like a framing byte, sometimes anyway
    task automatic send_data(input logic [7:0] d);
        if (d == FLAG_BYTE || d == ESC_BYTE || $urandom_range(0, 19) == 0)
            send_byte(ESC_BYTE, '0);
        send_byte(d, '0);
    endtask

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 15))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            2: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed frames, some short frames and raw noise
    task automatic send_random_frame();
        int         kind;
        int         len;
        logic [7:0] d;
        logic [7:0] sum;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 6);
            sum = 8'h00;
            for (int i = 0; i < len; i++) begin
                d   = (i == 0 && $urandom_range(0, 1) == 1) ? color_code : rand_data();
                sum = sum + d;
                send_data(d);
            end
            d = ~sum;
            if ($urandom_range(0, 6) == 0) d = d ^ 8'(1 << $urandom_range(0, 7));
            send_data(d);
            send_byte(FLAG_BYTE, '0);
        end else if (kind < 85) begin
            if ($urandom_range(0, 1) == 1) send_data(rand_data());
            send_byte(FLAG_BYTE, '0);
        end else begin
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(0, 3) == 0)
                    send_byte($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE, '0);
                else
                    send_byte(rand_data(), '0);
            end
        end
    endtask

    // hold the input until every report is out and the pipeline is empty
    task automatic wait_idle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        color_code = v;
        settings_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // receiver stall
    always @(posedge clk) begin
        res_stall <= ($urandom_range(0, 99) < res_stall_pct);
    end

    // compare each report transfer with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            report_count++;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: report with none expected, expected none actual ok=%0h len=%0d",
                         $time, checksum_ok, payload_length);
            end else begin
                want_report = expected_reports.pop_front();
                check_field("checksum_ok", 8'(want_report.checksum_ok), 8'(checksum_ok));
                check_field("payload_length", 8'(want_report.payload_length),
                            8'(payload_length));
                check_field("is_color", 8'(want_report.is_color), 8'(is_color));
                check_field("red", want_report.red, red);
                check_field("green", want_report.green, green);
                check_field("blue", want_report.blue, blue);
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // stimulus
    initial begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 8'h00;
        rx_valid       = 1'b0;
        rx_byte        = 8'h00;
        res_stall      = 1'b0;
        send_idle_pct  = 0;
        res_stall_pct  = 0;
        cycles         = 0;
        errors         = 0;
        rx_count       = 0;
        report_count   = 0;
        settings_count = 0;
        pause_count    = 0;
        esc_seen       = 1'b0;
        held_count     = 0;
        byte_sum       = 8'h00;
        tail_byte      = 8'h00;
        color_code     = COLOR_CODE_RESET;
        for (int i = 0; i < FRONT_DEPTH; i++) head_bytes[i] = 8'h00;

        // flag right after reset: short frame
        add_row(FLAG_BYTE, '0);
        // color command with a good checksum
        add_row(8'h63, '0);
        add_row(8'h01, '0);
        add_row(8'h02, '0);
        add_row(8'h03, '0);
        add_row(8'h96, '0);
        add_row(FLAG_BYTE, typed_report(1'b1, 4, 1'b1, 8'h01, 8'h02, 8'h03));
        // one byte only: short frame
        add_row(8'h55, '0);
        add_row(FLAG_BYTE, '0);
        // color command without color bytes: stale store positions
        add_row(8'h63, '0);
        add_row(8'h9C, '0);
        add_row(FLAG_BYTE, '0);
        // bad checksum
        add_row(8'h10, '0);
        add_row(8'h20, '0);
        add_row(8'h00, '0);
        add_row(FLAG_BYTE, typed_report(1'b0, 2, 1'b0, 8'h00, 8'h00, 8'h00));
        // escaped flag and escaped escape as data
        add_row(ESC_BYTE, '0);
        add_row(FLAG_BYTE, '0);
        add_row(ESC_BYTE, '0);
        add_row(ESC_BYTE, '0);
        add_row(8'h02, '0);
        add_row(FLAG_BYTE, '0);
        // zero payload, all-ones checksum
        add_row(8'h00, '0);
        add_row(ESC_BYTE, '0);
        add_row(FLAG_BYTE, '0);
        add_row(FLAG_BYTE, typed_report(1'b1, 1, 1'b0, 8'h00, 8'h00, 8'h00));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table at full rate with the reset color code
        foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed);

        // random blocks, each with a color code setting and one of four handshake modes
        for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
            wait_idle();
            case (blk)
                1: write_cfg(8'h00);
                2: write_cfg(8'hFF);
                3: write_cfg(COLOR_CODE_RESET);
                default: write_cfg(8'($urandom_range(0, 255)));
            endcase
            case (blk % 4)
                0: begin send_idle_pct = 0;  res_stall_pct = 0;  end
                1: begin send_idle_pct = 84; res_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  res_stall_pct = 84; end
                default: begin send_idle_pct = 31; res_stall_pct = 31; end
            endcase
            begin : fill_block
                int start_count;
                start_count = rx_count;
                while (rx_count - start_count < BLOCK_BYTES) send_random_frame();
            end
        end
        wait_idle();

        $display("covered %0d input bytes and %0d frame reports", rx_count, report_count);
        $display("over %0d color code settings, 4 handshake modes, %0d drain pauses",
                 settings_count + 1, pause_count + BLOCK_COUNT + 1);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d reports never seen", errors,
                     expected_reports.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== escaped_frame_checksum_deframer.f =====
design/efcd_pkg.sv
design/efcd_frame.sv
design/escaped_frame_checksum_deframer.sv
tb/testbench.sv
